// ----- hdl/kfcb_pkg.sv -----
// ----------------------------------------------------------------------------
// kfcb_pkg
// Shared widths, command codes and status bundle of the first-cycle
// bottleneck block.
// ----------------------------------------------------------------------------
package kfcb_pkg;

	localparam int VERT_BITS      = 10;
	localparam int MAX_VERTICES   = 1 << VERT_BITS;
	localparam int EDGE_ADDR_BITS = 10;
	localparam int MAX_EDGES      = 1 << EDGE_ADDR_BITS;
	localparam int COUNT_BITS     = EDGE_ADDR_BITS + 1;
	localparam int WEIGHT_BITS    = 20;
	localparam int RANK_BITS      = 4;
	localparam int EDGE_BITS      = WEIGHT_BITS + 2 * VERT_BITS;
	localparam int UF_BITS        = RANK_BITS + VERT_BITS;
	localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

	localparam int S_TDATA_BITS = ((EDGE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((WEIGHT_BITS + 7) / 8) * 8;

	// Datapath commands issued by the controller.
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CLEAR,
		OP_SORT_START,
		OP_SORT_OUTER,
		OP_SORT_RDCUR,
		OP_SORT_CHK,
		OP_SORT_CMP,
		OP_SORT_PLACE,
		OP_SCAN_START,
		OP_SCAN_OUTER,
		OP_SCAN_RD,
		OP_FIND_A,
		OP_FIND_B,
		OP_JOIN,
		OP_JOIN_RANK,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic load_last;
		logic clr_last;
		logic i_end;
		logic j_zero;
		logic gt;
		logic root_hit;
		logic same_set;
		logic rank_inc;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/kfcb_ram.sv -----
// ----------------------------------------------------------------------------
// kfcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kfcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/kfcb_ctrl.sv -----
// ----------------------------------------------------------------------------
// kfcb_ctrl
// Sequencer for load, clearing pass, insertion sort and union-find scan.
// ----------------------------------------------------------------------------
module kfcb_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  kfcb_pkg::sts_t sts,
	output kfcb_pkg::op_t  op
);
	import kfcb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_SORT_START, ST_SORT_OUTER, ST_SORT_RDCUR, ST_SORT_CHK,
		ST_SORT_CMP, ST_SORT_PLACE, ST_SCAN_START, ST_SCAN_OUTER, ST_SCAN_RD,
		ST_FIND_A, ST_FIND_B, ST_JOIN, ST_JOIN_RANK, ST_DONE
	} state_t;

	state_t state_q, state_d;
	op_t    op_q, op_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (sts.load_last) state_d = ST_CLEAR;
			ST_CLEAR:      if (sts.clr_last) state_d = ST_SORT_START;
			ST_SORT_START: state_d = ST_SORT_OUTER;
			ST_SORT_OUTER: state_d = sts.i_end ? ST_SCAN_START : ST_SORT_RDCUR;
			ST_SORT_RDCUR: state_d = ST_SORT_CHK;
			ST_SORT_CHK:   state_d = sts.j_zero ? ST_SORT_PLACE : ST_SORT_CMP;
			ST_SORT_CMP:   state_d = sts.gt ? ST_SORT_CHK : ST_SORT_PLACE;
			ST_SORT_PLACE: state_d = ST_SORT_OUTER;
			ST_SCAN_START: state_d = ST_SCAN_OUTER;
			ST_SCAN_OUTER: state_d = sts.i_end ? ST_DONE : ST_SCAN_RD;
			ST_SCAN_RD:    state_d = ST_FIND_A;
			ST_FIND_A:     if (sts.root_hit) state_d = ST_FIND_B;
			ST_FIND_B: begin
				if (sts.root_hit) begin
					state_d = sts.same_set ? ST_DONE : ST_JOIN;
				end
			end
			ST_JOIN:       state_d = sts.rank_inc ? ST_JOIN_RANK : ST_SCAN_OUTER;
			ST_JOIN_RANK:  state_d = ST_SCAN_OUTER;
			ST_DONE:       if (sts.out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_d)
			ST_IDLE:       op_d = OP_IDLE;
			ST_CLEAR:      op_d = OP_CLEAR;
			ST_SORT_START: op_d = OP_SORT_START;
			ST_SORT_OUTER: op_d = OP_SORT_OUTER;
			ST_SORT_RDCUR: op_d = OP_SORT_RDCUR;
			ST_SORT_CHK:   op_d = OP_SORT_CHK;
			ST_SORT_CMP:   op_d = OP_SORT_CMP;
			ST_SORT_PLACE: op_d = OP_SORT_PLACE;
			ST_SCAN_START: op_d = OP_SCAN_START;
			ST_SCAN_OUTER: op_d = OP_SCAN_OUTER;
			ST_SCAN_RD:    op_d = OP_SCAN_RD;
			ST_FIND_A:     op_d = OP_FIND_A;
			ST_FIND_B:     op_d = OP_FIND_B;
			ST_JOIN:       op_d = OP_JOIN;
			ST_JOIN_RANK:  op_d = OP_JOIN_RANK;
			ST_DONE:       op_d = OP_DONE;
			default:       op_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_IDLE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	assign op = op_q;

endmodule

// ----- hdl/kfcb_dp.sv -----
// ----------------------------------------------------------------------------
// kfcb_dp
// Datapath: edge store, union-find store, counters, running maximum and the
// result register.
// ----------------------------------------------------------------------------
module kfcb_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  kfcb_pkg::op_t                         op,
	output kfcb_pkg::sts_t                        sts,
	input  logic                                  cfg_we,
	input  logic [kfcb_pkg::VERT_BITS-1:0]        cfg_wdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [kfcb_pkg::VERT_BITS-1:0]        in_a,
	input  logic [kfcb_pkg::VERT_BITS-1:0]        in_b,
	input  logic [kfcb_pkg::WEIGHT_BITS-1:0]      in_w,
	input  logic                                  in_last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [kfcb_pkg::WEIGHT_BITS-1:0]      out_weight,
	output logic                                  out_error
);
	import kfcb_pkg::*;

	logic [VERT_BITS-1:0]   nv_q;
	logic [COUNT_BITS-1:0]  cnt_q, i_q, j_q;
	logic                   err_q;
	logic [WEIGHT_BITS-1:0] max_q;
	logic [VERT_BITS-1:0]   vr_q, x_q, b_q, ra_q, rb_q;
	logic [RANK_BITS-1:0]   rka_q, rkb_q;
	logic [EDGE_BITS-1:0]   cur_q;

	logic                      e_we;
	logic [EDGE_ADDR_BITS-1:0] e_waddr, e_raddr;
	logic [EDGE_BITS-1:0]      e_wdata, e_rdata;
	logic                      u_we;
	logic [VERT_BITS-1:0]      u_waddr, u_raddr;
	logic [UF_BITS-1:0]        u_wdata, u_rdata;

	logic                   acc, keep;
	logic [VERT_BITS-1:0]   u_par;
	logic [RANK_BITS-1:0]   u_rank;
	logic [VERT_BITS-1:0]   rd_a, rd_b;
	logic [WEIGHT_BITS-1:0] rd_w;

	assign s_tready = (op == OP_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign keep     = (in_a <= nv_q) && (in_b <= nv_q) && (cnt_q < COUNT_BITS'(MAX_EDGES));
	assign u_par    = u_rdata[VERT_BITS-1:0];
	assign u_rank   = u_rdata[UF_BITS-1:VERT_BITS];
	// Edge words hold weight on top, so a plain compare orders by weight, a, b.
	assign rd_b     = e_rdata[VERT_BITS-1:0];
	assign rd_a     = e_rdata[2*VERT_BITS-1:VERT_BITS];
	assign rd_w     = e_rdata[EDGE_BITS-1:2*VERT_BITS];

	assign sts.load_last = acc && in_last;
	assign sts.clr_last  = (vr_q == VERT_BITS'(MAX_VERTICES - 1));
	assign sts.i_end     = (i_q >= cnt_q);
	assign sts.j_zero    = (j_q == '0);
	assign sts.gt        = (e_rdata > cur_q);
	assign sts.root_hit  = (u_par == x_q);
	assign sts.same_set  = (x_q == ra_q);
	assign sts.rank_inc  = (rka_q == rkb_q) && (rkb_q != RANK_MAX);
	assign sts.out_free  = !out_valid || out_ready;

	always_comb begin
		e_we    = 1'b0;
		e_waddr = cnt_q[EDGE_ADDR_BITS-1:0];
		e_wdata = {in_w, in_a, in_b};
		e_raddr = i_q[EDGE_ADDR_BITS-1:0];
		unique case (op)
			OP_IDLE:     e_we = acc && keep;
			OP_SORT_CHK: e_raddr = j_q[EDGE_ADDR_BITS-1:0] - EDGE_ADDR_BITS'(1);
			OP_SORT_CMP: begin
				e_we    = sts.gt;
				e_waddr = j_q[EDGE_ADDR_BITS-1:0];
				e_wdata = e_rdata;
			end
			OP_SORT_PLACE: begin
				e_we    = 1'b1;
				e_waddr = j_q[EDGE_ADDR_BITS-1:0];
				e_wdata = cur_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		u_we    = 1'b0;
		u_waddr = vr_q;
		u_wdata = {{RANK_BITS{1'b0}}, vr_q};
		u_raddr = x_q;
		unique case (op)
			OP_CLEAR:   u_we = 1'b1;
			OP_SCAN_RD: u_raddr = rd_a;
			OP_FIND_A:  u_raddr = sts.root_hit ? b_q : u_par;
			OP_FIND_B:  u_raddr = u_par;
			OP_JOIN: begin
				u_we = 1'b1;
				if (rka_q > rkb_q) begin
					u_waddr = rb_q;
					u_wdata = {rkb_q, ra_q};
				end else begin
					u_waddr = ra_q;
					u_wdata = {rka_q, rb_q};
				end
			end
			OP_JOIN_RANK: begin
				u_we    = 1'b1;
				u_waddr = rb_q;
				u_wdata = {rkb_q + RANK_BITS'(1), rb_q};
			end
			default: ;
		endcase
	end

	kfcb_ram #(.WIDTH(EDGE_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	kfcb_ram #(.WIDTH(UF_BITS), .DEPTH(MAX_VERTICES)) u_uf_ram (
		.clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
		.raddr(u_raddr), .rdata(u_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q      <= VERT_BITS'(MAX_VERTICES - 1);
			cnt_q     <= '0;
			err_q     <= 1'b0;
			max_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			vr_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				nv_q <= cfg_wdata;
			end
			if (out_valid && out_ready && (op != OP_DONE)) begin
				out_valid <= 1'b0;
			end
			unique case (op)
				OP_IDLE: begin
					vr_q <= '0;
					if (acc) begin
						if (keep) begin
							cnt_q <= cnt_q + COUNT_BITS'(1);
						end else begin
							err_q <= 1'b1;
						end
					end
				end
				OP_CLEAR:      vr_q <= vr_q + VERT_BITS'(1);
				OP_SORT_START: i_q <= COUNT_BITS'(1);
				OP_SORT_RDCUR: j_q <= i_q;
				OP_SORT_CMP:   if (sts.gt) j_q <= j_q - COUNT_BITS'(1);
				OP_SORT_PLACE: i_q <= i_q + COUNT_BITS'(1);
				OP_SCAN_START: i_q <= '0;
				OP_SCAN_RD: begin
					i_q <= i_q + COUNT_BITS'(1);
					if (rd_w > max_q) begin
						max_q <= rd_w;
					end
				end
				OP_DONE: begin
					if (sts.out_free) begin
						out_valid <= 1'b1;
						cnt_q     <= '0;
						err_q     <= 1'b0;
						max_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_SORT_RDCUR: cur_q <= e_rdata;
			OP_SCAN_RD: begin
				x_q <= rd_a;
				b_q <= rd_b;
			end
			OP_FIND_A: begin
				if (sts.root_hit) begin
					ra_q  <= x_q;
					rka_q <= u_rank;
					x_q   <= b_q;
				end else begin
					x_q <= u_par;
				end
			end
			OP_FIND_B: begin
				if (sts.root_hit) begin
					rb_q  <= x_q;
					rkb_q <= u_rank;
				end else begin
					x_q <= u_par;
				end
			end
			OP_DONE: begin
				if (sts.out_free) begin
					out_weight <= max_q;
					out_error  <= err_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/kruskal_first_cycle_bottleneck.sv -----
// ----------------------------------------------------------------------------
// kruskal_first_cycle_bottleneck
// Bottleneck weight of a Kruskal scan up to the first cycle-forming edge.
// ----------------------------------------------------------------------------
// Edges are loaded at one transaction per cycle into a 1024-entry edge RAM.
// The transaction with tlast starts a run: a clearing pass over all 1024
// entries resets the parent/rank RAM, an insertion sort in the edge RAM
// then shifts each larger entry up by one until the edge fits, and the
// scan follows the parent links of each root search one hop at a time,
// all bounded by the single read port of each RAM. No edge is taken while
// a run is active; the result sits in an output register until it is
// taken, and loading of the next graph goes on meanwhile.
module kruskal_first_cycle_bottleneck (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [kfcb_pkg::VERT_BITS-1:0]       cfg_wdata,     // highest valid vertex index
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// end_a [9:0], end_b [19:10], edge_weight [39:20]
	input  logic [kfcb_pkg::S_TDATA_BITS-1:0]    s_tdata,
	input  logic                                 s_tlast,       // last_edge
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// bottleneck_weight [19:0], zero fill
	output logic [kfcb_pkg::M_TDATA_BITS-1:0]    m_tdata,
	output logic                                 m_tuser        // error
);
	import kfcb_pkg::*;

	op_t                    op;
	sts_t                   sts;
	logic [WEIGHT_BITS-1:0] out_weight;

	kfcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .op(op)
	);

	kfcb_dp u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .sts(sts),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.in_a(s_tdata[VERT_BITS-1:0]),
		.in_b(s_tdata[2*VERT_BITS-1:VERT_BITS]),
		.in_w(s_tdata[EDGE_BITS-1:2*VERT_BITS]),
		.in_last(s_tlast),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_weight(out_weight), .out_error(m_tuser)
	);

	assign m_tdata = M_TDATA_BITS'(out_weight);

endmodule

// ----- verif/kfcb_checker.sv -----
// ----------------------------------------------------------------------------
// kfcb_checker
// Watches the edge and result streams of the first-cycle bottleneck block.
// It keeps its own copy of the loaded graph and computes the expected
// bottleneck weight and error flag for every graph closed by tlast.
// ----------------------------------------------------------------------------
module kfcb_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [kfcb_pkg::VERT_BITS-1:0]       cfg_wdata,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [kfcb_pkg::S_TDATA_BITS-1:0]    s_tdata,
	input  logic                                 s_tlast,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [kfcb_pkg::M_TDATA_BITS-1:0]    m_tdata,
	input  logic                                 m_tuser,
	output int                                   fail_count,
	output int                                   pending
);
	import kfcb_pkg::*;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [VERT_BITS-1:0]   va;
		logic [VERT_BITS-1:0]   vb;
	} graph_edge_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] bottleneck;
		logic                   err;
	} bottleneck_t;

	graph_edge_t            graph[$];
	bottleneck_t            expected_q[$];
	logic [VERT_BITS-1:0]   top_vertex;
	logic                   graph_err;
	int unsigned            parent[MAX_VERTICES];
	int unsigned            rnk[MAX_VERTICES];

	function automatic int unsigned root_of(int unsigned v);
		int unsigned r;
		int unsigned n;
		r = v;
		while (parent[r] != r)
			r = parent[r];
		while (parent[v] != r) begin
			n = parent[v];
			parent[v] = r;
			v = n;
		end
		return r;
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] first_cycle_weight();
		logic [WEIGHT_BITS-1:0] best;
		int unsigned ra;
		int unsigned rb;
		best = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			parent[i] = i;
			rnk[i] = 0;
		end
		// The packed edge orders by weight, then end_a, then end_b.
		graph.sort() with (item);
		foreach (graph[i]) begin
			ra = root_of(graph[i].va);
			rb = root_of(graph[i].vb);
			if (graph[i].weight > best)
				best = graph[i].weight;
			if (ra == rb)
				break;
			if (rnk[ra] > rnk[rb]) begin
				parent[rb] = ra;
			end else begin
				parent[ra] = rb;
				if (rnk[ra] == rnk[rb] && rnk[rb] < RANK_MAX)
					rnk[rb]++;
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		graph_edge_t  e;
		bottleneck_t  got;
		bottleneck_t  want;
		if (!arst_n) begin
			graph.delete();
			expected_q.delete();
			top_vertex <= '1;
			graph_err = 1'b0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				top_vertex <= cfg_wdata;
			if (s_tvalid && s_tready) begin
				e.va = s_tdata[9:0];
				e.vb = s_tdata[19:10];
				e.weight = s_tdata[39:20];
				if (e.va > top_vertex || e.vb > top_vertex || graph.size() >= MAX_EDGES)
					graph_err = 1'b1;
				else
					graph.insert(graph.size(), e);
				if (s_tlast) begin
					want.bottleneck = first_cycle_weight();
					want.err = graph_err;
					expected_q.insert(expected_q.size(), want);
					graph.delete();
					graph_err = 1'b0;
				end
			end
			if (m_tvalid && m_tready) begin
				got.bottleneck = m_tdata[WEIGHT_BITS-1:0];
				got.err = m_tuser;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction: weight %0d error %0b",
							got.bottleneck, got.err);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got != want) begin
						if (fail_count < 10)
							$display("result mismatch: expected weight %0d error %0b, got %0d %0b",
								want.bottleneck, want.err, got.bottleneck, got.err);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the first-cycle bottleneck block: directed graphs, then
// random graphs under several vertex limits, with random idling on both
// streams and one long result hold-off. The checker compares, this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import kfcb_pkg::*;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int HOLDOFF_CYCLES = 3000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [VERT_BITS-1:0]      cfg_wdata;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [S_TDATA_BITS-1:0]   s_tdata;
	logic                      s_tlast;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [M_TDATA_BITS-1:0]   m_tdata;
	logic                      m_tuser;
	int                        fail_count;
	int                        pending;
	int                        cycles = 0;
	int                        idle_pct;
	int                        holdoff;
	logic                      holdoff_go;
	logic                      holdoff_done;
	logic [VERT_BITS-1:0]      top_vertex;

	kruskal_first_cycle_bottleneck i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	kfcb_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off once requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			holdoff <= 0;
			holdoff_done <= 1'b0;
		end else if (holdoff_go && !holdoff_done) begin
			m_tready <= 1'b0;
			holdoff <= holdoff + 1;
			if (holdoff == HOLDOFF_CYCLES - 1)
				holdoff_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// tvalid stays high after a transaction so that edges can follow back to back.
	task automatic send_edge(input int a, input int b, input int w, input bit last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_BITS'({w[WEIGHT_BITS-1:0], b[VERT_BITS-1:0], a[VERT_BITS-1:0]});
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic set_top_vertex(input int v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= VERT_BITS'(v);
		top_vertex = VERT_BITS'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// A random graph with mostly in-range endpoints and a mix of small and full-range weights.
	task automatic send_graph(input int n);
		int a;
		int b;
		int w;
		for (int i = 0; i < n; i++) begin
			a = ($urandom_range(99) < 5) ? $urandom_range(1023) : $urandom_range(top_vertex);
			b = ($urandom_range(99) < 5) ? $urandom_range(1023) : $urandom_range(top_vertex);
			w = ($urandom_range(1)) ? $urandom_range(40) : $urandom;
			send_edge(a, b, w & 20'hFFFFF, i == n - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		idle_pct = 18;
		holdoff_go = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		top_vertex = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, a single edge, a triangle, duplicate weights.
		send_edge(0, 1023, 20'hFFFFF, 1'b1);
		send_edge(5, 5, 0, 1'b1);
		send_edge(1, 2, 7, 1'b0);
		send_edge(2, 3, 3, 1'b0);
		send_edge(1, 3, 9, 1'b0);
		send_edge(0, 1, 9, 1'b1);
		send_edge(1023, 0, 20'hAAAAA, 1'b0);
		send_edge(682, 341, 20'h55555, 1'b1);
		set_top_vertex(1);
		send_edge(2, 0, 4, 1'b0);       // out of range, dropped
		send_edge(0, 1, 6, 1'b1);
		send_edge(3, 1000, 6, 1'b1);    // empty graph with error
		set_top_vertex(1023);
		// Capacity: one edge beyond the edge store, as a chain so sort stays cheap.
		for (int i = 0; i <= MAX_EDGES; i++)
			send_edge(i % 1023, (i + 1) % 1023, i, i == MAX_EDGES);

		// Long result hold-off while edges keep coming.
		holdoff_go <= 1'b1;
		send_graph(6);
		send_graph(6);
		send_graph(6);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_top_vertex(3);
				1: set_top_vertex($urandom_range(10, 60));
				2: set_top_vertex(1023);
				default: set_top_vertex(1);
			endcase
			idle_pct = (phase == 2) ? 0 : 18;
			for (int g = 0; g < 5; g++)
				send_graph($urandom_range(1, 14));
		end
		idle_pct = 18;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
